>>> hdl/strided_dma_address_generator_macros.svh
// ----------------------------------------------------------------------------
// strided dma address generator assertion macros
// shared concurrent assertion forms, clocked on clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef STRIDED_DMA_ADDRESS_GENERATOR_MACROS_SVH
`define STRIDED_DMA_ADDRESS_GENERATOR_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define SDAG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define SDAG_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/sdag_pkg.sv
// ----------------------------------------------------------------------------
// sdag_pkg
// widths, field types and opcodes of the strided dma address generator
// ----------------------------------------------------------------------------
package sdag_pkg;

	localparam int LOCAL_ADDR_BITS = 12;
	localparam int MAIN_ADDR_BITS  = 24;
	// row length field of the length word, bits 11..0
	localparam int ROW_LEN_BITS    = 12;
	localparam int ROW_BYTES_BITS  = ROW_LEN_BITS + 1;
	localparam int ROWS_BITS       = 9;
	localparam int SKIP_BITS       = 12;
	localparam int SWIZZLE_BITS    = 2;
	localparam int LENGTH_BITS     = 32;

	localparam logic [SWIZZLE_BITS-1:0] SWIZZLE_RESET = 2'd3;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} opcode_t;

	typedef logic [LOCAL_ADDR_BITS-1:0] local_addr_t;
	typedef logic [MAIN_ADDR_BITS-1:0]  main_addr_t;
	typedef logic [LOCAL_ADDR_BITS:0]   local_addr_bank_t;
	typedef logic [LENGTH_BITS-1:0]     length_word_t;
	typedef logic [SWIZZLE_BITS-1:0]    swizzle_t;

	typedef struct packed {
		logic        valid_res;
		logic        bank;
		local_addr_t local_byte_address;
		main_addr_t  main_byte_address;
		logic        direction;
		logic        last;
	} res_t;

endpackage

>>> hdl/sdag_if.sv
// ----------------------------------------------------------------------------
// sdag interfaces
// command, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface sdag_cmd_if;
	logic                  valid;
	logic                  ready;
	sdag_pkg::opcode_t     opcode;
	sdag_pkg::length_word_t length_word;
	sdag_pkg::local_addr_bank_t local_address;
	sdag_pkg::main_addr_t  main_address;
	logic                  to_main;

	modport source (output valid, opcode, length_word, local_address, main_address, to_main,
		input ready);
	modport sink (input valid, opcode, length_word, local_address, main_address, to_main,
		output ready);
endinterface

interface sdag_res_if;
	logic                  valid;
	logic                  ready;
	logic                  valid_res;
	logic                  bank;
	sdag_pkg::local_addr_t local_byte_address;
	sdag_pkg::main_addr_t  main_byte_address;
	logic                  direction;
	logic                  last;

	modport source (output valid, valid_res, bank, local_byte_address, main_byte_address,
		direction, last, input ready);
	modport sink (input valid, valid_res, bank, local_byte_address, main_byte_address,
		direction, last, output ready);
endinterface

interface sdag_cfg_if;
	logic               valid;
	logic               ready;
	sdag_pkg::swizzle_t data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> hdl/strided_dma_address_generator.sv
// ----------------------------------------------------------------------------
// strided_dma_address_generator
// result: registered, on the output register in the cycle after the command transfer
// throughput: one command per cycle while results are taken, set by the single output register stage
// ready drops only while a held result is not taken
// reset: async active low, idle, swizzle 3, all pointers and counters zero
// ----------------------------------------------------------------------------
module strided_dma_address_generator (
	input  logic        clk,
	input  logic        arst_n,
	sdag_cmd_if.sink    cmd,
	sdag_res_if.source  res,
	sdag_cfg_if.sink    cfg
);
	import sdag_pkg::*;

	// transfer state, updated at each accepted start command and at each accepted step while busy
	logic                      busy_q;
	logic                      bank_select_q;
	logic                      direction_held_q;
	local_addr_t               local_pointer_q;
	main_addr_t                main_pointer_q;
	logic [ROW_BYTES_BITS-1:0] row_bytes_q;
	logic [ROW_BYTES_BITS-1:0] byte_in_row_q;
	logic [ROWS_BITS-1:0]      rows_left_q;
	logic [SKIP_BITS-1:0]      row_skip_q;
	swizzle_t                  swizzle_q;

	// output register
	logic res_valid_q;
	res_t res_q;

	logic                      accept;
	logic                      is_step;
	logic                      at_row_end;
	logic                      is_last;
	logic [ROW_BYTES_BITS:0]   byte_next;
	main_addr_t                main_skip;
	res_t                      res_d;

	// a new command goes in whenever the output register is free or being drained
	assign cmd.ready = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign is_step   = (cmd.opcode == OP_STEP) && busy_q;

	// configuration is always taken
	assign cfg.ready = 1'b1;

	// row end when the next byte count reaches the row length
	assign byte_next  = {1'b0, byte_in_row_q} + (ROW_BYTES_BITS+1)'(1);
	assign at_row_end = byte_next >= {1'b0, row_bytes_q};
	assign is_last    = at_row_end && (rows_left_q <= ROWS_BITS'(1));

	// main address moves one byte, plus the skip at the end of a row
	assign main_skip = at_row_end ? MAIN_ADDR_BITS'(row_skip_q) : '0;

	// result fields; start and idle steps give an all-zero non-transfer result
	always_comb begin
		res_d = '0;
		if (is_step) begin
			res_d.valid_res          = 1'b1;
			res_d.bank               = bank_select_q;
			res_d.local_byte_address = local_pointer_q ^ LOCAL_ADDR_BITS'(swizzle_q);
			res_d.main_byte_address  = main_pointer_q ^ MAIN_ADDR_BITS'(swizzle_q);
			res_d.direction          = direction_held_q;
			res_d.last               = is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swizzle_q <= SWIZZLE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			swizzle_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q           <= 1'b0;
			bank_select_q    <= 1'b0;
			direction_held_q <= 1'b0;
			local_pointer_q  <= '0;
			main_pointer_q   <= '0;
			row_bytes_q      <= '0;
			byte_in_row_q    <= '0;
			rows_left_q      <= '0;
			row_skip_q       <= '0;
		end else if (accept) begin
			if (cmd.opcode == OP_START) begin
				// latch a new strided transfer, dropping any running one
				row_bytes_q      <= {1'b0, cmd.length_word[ROW_LEN_BITS-1:0]
					| ROW_LEN_BITS'(7)} + ROW_BYTES_BITS'(1);
				rows_left_q      <= {1'b0, cmd.length_word[19:12]} + ROWS_BITS'(1);
				row_skip_q       <= cmd.length_word[31:20];
				local_pointer_q  <= cmd.local_address[LOCAL_ADDR_BITS-1:0];
				bank_select_q    <= cmd.local_address[LOCAL_ADDR_BITS];
				main_pointer_q   <= cmd.main_address;
				direction_held_q <= cmd.to_main;
				byte_in_row_q    <= '0;
				busy_q           <= 1'b1;
			end else if (busy_q) begin
				local_pointer_q <= local_pointer_q + LOCAL_ADDR_BITS'(1);
				main_pointer_q  <= main_pointer_q + MAIN_ADDR_BITS'(1) + main_skip;
				if (at_row_end) begin
					byte_in_row_q <= '0;
					if (is_last) begin
						rows_left_q <= '0;
						busy_q      <= 1'b0;
					end else begin
						rows_left_q <= rows_left_q - ROWS_BITS'(1);
					end
				end else begin
					byte_in_row_q <= byte_next[ROW_BYTES_BITS-1:0];
				end
			end
		end
	end

	// output register: loads on each command transfer, clears when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign res.valid              = res_valid_q;
	assign res.valid_res          = res_q.valid_res;
	assign res.bank               = res_q.bank;
	assign res.local_byte_address = res_q.local_byte_address;
	assign res.main_byte_address  = res_q.main_byte_address;
	assign res.direction          = res_q.direction;
	assign res.last               = res_q.last;

endmodule

>>> hdl/sdag_checker.sv
// ----------------------------------------------------------------------------
// sdag_checker
// port-level checks of the strided dma address generator, bound to the top
// ----------------------------------------------------------------------------
`include "strided_dma_address_generator_macros.svh"

module sdag_checker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic cmd_opcode,
	input logic res_valid,
	input logic res_ready,
	input logic res_valid_res,
	input logic res_last
);
	import sdag_pkg::*;

	// stalled result holds
	`SDAG_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_last))
	// every command transfer shows its result in the next cycle
	`SDAG_ASSERT_NEXT(a_cmd_to_res, cmd_valid && cmd_ready, res_valid)
	// a start command gives a non-transfer result
	`SDAG_ASSERT_NEXT(a_start_idle, cmd_valid && cmd_ready && (cmd_opcode == OP_START),
		!res_valid_res && !res_last)
	// with the output register empty the command side is never stalled
	`SDAG_ASSERT_SAME(a_ready_free, !res_valid, cmd_ready)

endmodule

bind strided_dma_address_generator sdag_checker u_sdag_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.cmd_opcode    (cmd.opcode),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_valid_res (res.valid_res),
	.res_last      (res.last)
);
